@@ design/jsu_pkg.sv @@
`default_nettype none
package jsu_pkg;

  typedef enum logic [1:0] {
    PH_PLAIN = 2'd0,
    PH_ESC   = 2'd1,
    PH_HEX   = 2'd2
  } jsu_phase_t;

  localparam int unsigned MAX_RES = 3;

  localparam logic [7:0] TOP_BIT    = 8'h80;
  localparam logic [1:0] HEX_LAST   = 2'd3;

  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_B       = 8'h62;
  localparam logic [7:0] CH_F       = 8'h66;
  localparam logic [7:0] CH_N       = 8'h6E;
  localparam logic [7:0] CH_R       = 8'h72;
  localparam logic [7:0] CH_T       = 8'h74;
  localparam logic [7:0] CH_U       = 8'h75;

  localparam logic [7:0] BYTE_BS    = 8'h08;
  localparam logic [7:0] BYTE_FF    = 8'h0C;
  localparam logic [7:0] BYTE_LF    = 8'h0A;
  localparam logic [7:0] BYTE_CR    = 8'h0D;
  localparam logic [7:0] BYTE_TAB   = 8'h09;

  // results caused by one input item
  typedef struct packed {
    logic [1:0]         cnt;
    logic               done;
    logic [2:0][7:0]    bytes;
  } jsu_grp_t;

endpackage
`default_nettype wire

@@ design/jsu_if.sv @@
`default_nettype none
interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       string_done;
  logic       last;

  modport source (output valid, output out_byte, output byte_valid,
                  output string_done, output last, input ready);
  modport sink   (input valid, input out_byte, input byte_valid,
                  input string_done, input last, output ready);
endinterface
`default_nettype wire

@@ design/jsu_decode.sv @@
`default_nettype none
module jsu_decode (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [7:0]       byte_i,
  input  wire logic             take,
  output jsu_pkg::jsu_grp_t     grp
);
  import jsu_pkg::*;

  jsu_phase_t  phase_r, phase_nxt;
  logic [1:0]  hex_count_r, hex_count_nxt;
  logic [15:0] code_point_r, code_point_nxt;
  logic        hex_bad_r, hex_bad_nxt;

  logic        hex_ok;
  logic [3:0]  hex_val;
  logic [15:0] cp;

  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    if (byte_i >= 8'h30 && byte_i <= 8'h39) begin
      hex_val = 4'(byte_i - 8'h30);
    end else if (byte_i >= 8'h61 && byte_i <= 8'h66) begin
      hex_val = 4'(byte_i - 8'h57);
    end else if (byte_i >= 8'h41 && byte_i <= 8'h46) begin
      hex_val = 4'(byte_i - 8'h37);
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign cp = {code_point_r[11:0], hex_val};

  always_comb begin
    phase_nxt      = phase_r;
    hex_count_nxt  = hex_count_r;
    code_point_nxt = code_point_r;
    hex_bad_nxt    = hex_bad_r;
    grp            = '0;
    unique case (phase_r)
      PH_ESC: begin
        phase_nxt = PH_PLAIN;
        grp.cnt   = 2'd1;
        unique case (byte_i)
          CH_QUOTE:  grp.bytes[0] = CH_QUOTE;
          CH_BSLASH: grp.bytes[0] = CH_BSLASH;
          CH_SLASH:  grp.bytes[0] = CH_SLASH;
          CH_B:      grp.bytes[0] = BYTE_BS;
          CH_F:      grp.bytes[0] = BYTE_FF;
          CH_N:      grp.bytes[0] = BYTE_LF;
          CH_R:      grp.bytes[0] = BYTE_CR;
          CH_T:      grp.bytes[0] = BYTE_TAB;
          CH_U: begin
            grp.cnt        = 2'd0;
            phase_nxt      = PH_HEX;
            hex_count_nxt  = 2'd0;
            code_point_nxt = '0;
            hex_bad_nxt    = 1'b0;
          end
          default: grp.cnt = 2'd0;  // unknown escape is dropped
        endcase
      end
      PH_HEX: begin
        code_point_nxt = cp;
        if (hex_count_r != HEX_LAST) begin
          hex_count_nxt = hex_count_r + 2'd1;
          hex_bad_nxt   = hex_bad_r | ~hex_ok;
        end else begin
          phase_nxt     = PH_PLAIN;
          hex_count_nxt = 2'd0;
          hex_bad_nxt   = 1'b0;
          if (!hex_bad_r && hex_ok) begin
            if (cp < 16'h0080) begin
              grp.cnt      = 2'd1;
              grp.bytes[0] = cp[7:0];
            end else if (cp < 16'h0800) begin
              grp.cnt      = 2'd2;
              grp.bytes[0] = {3'b110, cp[10:6]};
              grp.bytes[1] = {2'b10, cp[5:0]};
            end else begin
              grp.cnt      = 2'd3;
              grp.bytes[0] = {4'b1110, cp[15:12]};
              grp.bytes[1] = {2'b10, cp[11:6]};
              grp.bytes[2] = {2'b10, cp[5:0]};
            end
          end
        end
      end
      default: begin
        // plain text, also the unreachable phase code
        phase_nxt = PH_PLAIN;
        grp.cnt   = 2'd1;
        if ((byte_i & TOP_BIT) != 8'h00) begin
          grp.bytes[0] = byte_i;
        end else if (byte_i == CH_BSLASH) begin
          grp.cnt   = 2'd0;
          phase_nxt = PH_ESC;
        end else if (byte_i == CH_QUOTE) begin
          grp.done = 1'b1;
        end else begin
          grp.bytes[0] = byte_i;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_PLAIN;
      hex_count_r  <= 2'd0;
      code_point_r <= '0;
      hex_bad_r    <= 1'b0;
    end else if (take) begin
      phase_r      <= phase_nxt;
      hex_count_r  <= hex_count_nxt;
      code_point_r <= code_point_nxt;
      hex_bad_r    <= hex_bad_nxt;
    end
  end

endmodule
`default_nettype wire

@@ design/jsu_emit.sv @@
`default_nettype none
module jsu_emit (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire jsu_pkg::jsu_grp_t grp_in,
  input  wire logic             load,
  output logic                  free,
  jsu_out_if.source             out_ch
);
  import jsu_pkg::*;

  logic       vld_r;
  jsu_grp_t   grp_r;
  logic [1:0] idx_r;
  logic       at_last;
  logic       fire;

  assign at_last = (idx_r == grp_r.cnt - 2'd1);
  assign fire    = vld_r && out_ch.ready;
  assign free    = !vld_r || (fire && at_last);

  assign out_ch.valid       = vld_r;
  assign out_ch.out_byte    = grp_r.done ? 8'h00 : grp_r.bytes[idx_r];
  assign out_ch.byte_valid  = !grp_r.done;
  assign out_ch.string_done = grp_r.done;
  assign out_ch.last        = at_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      idx_r <= 2'd0;
    end else if (load) begin
      vld_r <= 1'b1;
      idx_r <= 2'd0;
    end else if (fire) begin
      if (at_last) begin
        vld_r <= 1'b0;
      end else begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      grp_r <= grp_in;
    end
  end

endmodule
`default_nettype wire

@@ design/json_string_unescape.sv @@
`default_nettype none
// each accepted item is registered, then its results are registered for output
// throughput: one input item per cycle; results leave one per cycle while
// out_ch.ready is high, a \u escape gives up to 3 results from its final digit,
// and the next item with results waits in the input register while they drain
// reset: synchronous active-low rst_n clears the decode phase and escape state and
// empties the input and result registers
module json_string_unescape (
  input  wire logic  clk,
  input  wire logic  rst_n,
  jsu_in_if.sink     in_ch,
  jsu_out_if.source  out_ch
);
  import jsu_pkg::*;

  logic       in_vld_r;
  logic [7:0] in_byte_r;
  jsu_grp_t   grp;
  logic       emit_free;
  logic       dec_take;
  logic       load;

  assign dec_take    = in_vld_r && ((grp.cnt == 2'd0) || emit_free);
  assign load        = dec_take && (grp.cnt != 2'd0);
  assign in_ch.ready = !in_vld_r || dec_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_byte_r <= in_ch.in_byte;
    end
  end

  jsu_decode u_decode (
    .clk    (clk),
    .rst_n  (rst_n),
    .byte_i (in_byte_r),
    .take   (dec_take),
    .grp    (grp)
  );

  jsu_emit u_emit (
    .clk    (clk),
    .rst_n  (rst_n),
    .grp_in (grp),
    .load   (load),
    .free   (emit_free),
    .out_ch (out_ch)
  );

  // a done result never carries a byte and always closes its item
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.string_done |-> out_ch.last && !out_ch.byte_valid)
    else $error("done result without last or with a byte");

  // results of one item follow without a gap in valid
  a_group_cont: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.ready && !out_ch.last |=> out_ch.valid)
    else $error("result group broken off");

  // a decoded item with results shows up at the output next cycle
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> out_ch.valid)
    else $error("loaded results not offered");

endmodule
`default_nettype wire

@@ test/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
  import jsu_pkg::*;

  typedef struct packed {
    logic [7:0] ob;
    logic       bv;
    logic       done;
    logic       last;
  } decoded_t;

  // how a directed row is checked: by the predictor, or by the typed-in result
  typedef enum logic [1:0] {
    ROW_PRED,
    ROW_NONE,
    ROW_BYTE,
    ROW_DONE
  } row_kind_t;

  typedef struct packed {
    row_kind_t  kind;
    logic [7:0] b;
    logic [7:0] ob;
  } dir_row_t;

  localparam int DIR_ROWS = 28;
  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    '{ROW_BYTE, 8'h00,     8'h00},
    '{ROW_BYTE, 8'hFF,     8'hFF},
    '{ROW_DONE, CH_QUOTE,  8'h00},
    // a new string body starts right after the closing quote
    '{ROW_BYTE, "A",       "A"},
    '{ROW_NONE, CH_BSLASH, 8'h00},
    '{ROW_BYTE, CH_N,      BYTE_LF},
    '{ROW_NONE, CH_BSLASH, 8'h00},
    '{ROW_BYTE, CH_BSLASH, CH_BSLASH},
    '{ROW_NONE, CH_BSLASH, 8'h00},
    '{ROW_BYTE, CH_QUOTE,  CH_QUOTE},
    // unknown escape, top-bit byte dropped with its backslash
    '{ROW_NONE, CH_BSLASH, 8'h00},
    '{ROW_NONE, 8'hFF,     8'h00},
    '{ROW_NONE, CH_BSLASH, 8'h00},
    '{ROW_NONE, CH_U,      8'h00},
    '{ROW_NONE, "0",       8'h00},
    '{ROW_NONE, "0",       8'h00},
    '{ROW_NONE, "0",       8'h00},
    '{ROW_BYTE, "0",       8'h00},
    // surrogate, three bytes with no pairing
    '{ROW_NONE, CH_BSLASH, 8'h00},
    '{ROW_NONE, CH_U,      8'h00},
    '{ROW_PRED, "d",       8'h00},
    '{ROW_PRED, "F",       8'h00},
    '{ROW_PRED, "f",       8'h00},
    '{ROW_PRED, "F",       8'h00},
    // quote inside the hex digits is just a bad digit
    '{ROW_NONE, CH_BSLASH, 8'h00},
    '{ROW_NONE, CH_U,      8'h00},
    '{ROW_NONE, CH_QUOTE,  8'h00},
    '{ROW_NONE, "7",       8'h00}
  };

  localparam int IDLE_PCT  [4] = '{0, 53, 0, 12};
  localparam int STALL_PCT [4] = '{0, 0, 53, 12};
  localparam int ITEMS_PER_PHASE = 100;

  localparam logic [7:0] ESC_CHARS [8] = '{CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B,
                                           CH_F, CH_N, CH_R, CH_T};

  logic clk;
  logic rst_n;

  jsu_in_if  in_ch ();
  jsu_out_if out_ch ();

  json_string_unescape DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // predictor state
  jsu_phase_t  dec_phase = PH_PLAIN;
  logic [1:0]  dig_cnt   = '0;
  logic [15:0] cp_acc    = '0;
  logic        cp_bad    = 1'b0;

  decoded_t decoded_q [$];

  int idle_pct  = 0;
  int stall_pct = 0;
  int n_items   = 0;
  int n_results = 0;
  int n_strings = 0;
  int n_errors  = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d results still expected", decoded_q.size());
    $display("json_string_unescape verification failed");
    $finish;
  end

  // {is_hex, nibble}
  function automatic logic [4:0] hex_val(logic [7:0] c);
    logic [7:0] d;
    if (c >= "0" && c <= "9") begin
      d = c - "0";
      return {1'b1, d[3:0]};
    end
    if (c >= "a" && c <= "f") begin
      d = c - "a" + 8'd10;
      return {1'b1, d[3:0]};
    end
    if (c >= "A" && c <= "F") begin
      d = c - "A" + 8'd10;
      return {1'b1, d[3:0]};
    end
    return 5'b0;
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] v, bit upper);
    if (v < 4'd10) return "0" + v;
    return (upper ? "A" : "a") + v - 8'd10;
  endfunction

  // appends one expected result at the tail of the queue
  function automatic void expect_result(decoded_t r);
    decoded_q = {decoded_q, r};
  endfunction

  // advances the decoder state by one byte; keep=0 drops the predicted results
  function automatic void unescape_predict(logic [7:0] c, bit keep);
    logic [7:0] enc [MAX_RES];
    logic [4:0] hv;
    int n;
    bit is_done;
    n = 0;
    is_done = 0;
    case (dec_phase)
      PH_ESC: begin
        dec_phase = PH_PLAIN;
        case (c)
          CH_QUOTE, CH_BSLASH, CH_SLASH: begin enc[0] = c;        n = 1; end
          CH_B: begin                          enc[0] = BYTE_BS;  n = 1; end
          CH_F: begin                          enc[0] = BYTE_FF;  n = 1; end
          CH_N: begin                          enc[0] = BYTE_LF;  n = 1; end
          CH_R: begin                          enc[0] = BYTE_CR;  n = 1; end
          CH_T: begin                          enc[0] = BYTE_TAB; n = 1; end
          CH_U: begin
            dec_phase = PH_HEX;
            dig_cnt = '0;
            cp_acc = '0;
            cp_bad = 1'b0;
          end
          default: ;
        endcase
      end
      PH_HEX: begin
        hv = hex_val(c);
        if (!hv[4]) cp_bad = 1'b1;
        cp_acc = {cp_acc[11:0], hv[3:0]};
        if (dig_cnt != HEX_LAST) begin
          dig_cnt = dig_cnt + 2'd1;
        end else begin
          dec_phase = PH_PLAIN;
          dig_cnt = '0;
          if (cp_bad) begin
            cp_bad = 1'b0;
          end else if (cp_acc < 16'h0080) begin
            enc[0] = cp_acc[7:0];
            n = 1;
          end else if (cp_acc < 16'h0800) begin
            enc[0] = {3'b110, cp_acc[10:6]};
            enc[1] = {2'b10, cp_acc[5:0]};
            n = 2;
          end else begin
            enc[0] = {4'b1110, cp_acc[15:12]};
            enc[1] = {2'b10, cp_acc[11:6]};
            enc[2] = {2'b10, cp_acc[5:0]};
            n = 3;
          end
        end
      end
      default: begin
        dec_phase = PH_PLAIN;
        if ((c & TOP_BIT) != 8'h00) begin
          enc[0] = c;
          n = 1;
        end else if (c == CH_BSLASH) begin
          dec_phase = PH_ESC;
        end else if (c == CH_QUOTE) begin
          enc[0] = 8'h00;
          is_done = 1;
          n = 1;
        end else begin
          enc[0] = c;
          n = 1;
        end
      end
    endcase
    if (keep)
      for (int k = 0; k < n; k++)
        expect_result(decoded_t'{enc[k], !is_done, is_done, k == n - 1});
  endfunction

  task automatic report_mismatch(string msg);
    n_errors++;
    $display("[%0t] MISMATCH %s", $realtime, msg);
  endtask

  task automatic send_item(logic [7:0] b, row_kind_t kind = ROW_PRED,
                           logic [7:0] ob = 8'h00);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    n_items++;
    unescape_predict(b, kind == ROW_PRED);
    if (kind == ROW_BYTE) expect_result(decoded_t'{ob, 1'b1, 1'b0, 1'b1});
    if (kind == ROW_DONE) expect_result(decoded_t'{8'h00, 1'b0, 1'b1, 1'b1});
  endtask

  task automatic send_uescape(logic [15:0] cp, bit broken);
    int bad_pos;
    logic [7:0] c;
    bad_pos = broken ? $urandom_range(3) : 4;
    send_item(CH_BSLASH);
    send_item(CH_U);
    for (int k = 0; k < 4; k++) begin
      c = hex_char(cp[15 - 4 * k -: 4], 1'($urandom_range(1)));
      if (k == bad_pos) begin
        case ($urandom_range(2))
          0: c = CH_QUOTE;
          1: c = CH_BSLASH;
          default: do c = 8'($urandom_range(255)); while (hex_val(c) != 5'b0);
        endcase
      end
      send_item(c);
    end
  endtask

  task automatic send_token();
    logic [7:0] c;
    logic [15:0] cp;
    int pick;
    pick = $urandom_range(99);
    if (pick < 30) begin
      do c = 8'($urandom_range(126, 32)); while (c == CH_QUOTE || c == CH_BSLASH);
      send_item(c);
    end else if (pick < 38) begin
      c = 8'($urandom_range(255, 128));
      send_item(c);
    end else if (pick < 43) begin
      c = 8'($urandom_range(31));
      send_item(c);
    end else if (pick < 60) begin
      send_item(CH_BSLASH);
      send_item(ESC_CHARS[3'($urandom_range(7))]);
    end else if (pick < 66) begin
      do c = 8'($urandom_range(255));
      while (c inside {CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T, CH_U});
      send_item(CH_BSLASH);
      send_item(c);
    end else if (pick < 89) begin
      case ($urandom_range(4))
        0: cp = 16'($urandom_range(16'h007F));
        1: cp = 16'($urandom_range(16'h07FF, 16'h0080));
        2: cp = 16'($urandom_range(16'hFFFF, 16'h0800));
        3: cp = 16'($urandom_range(16'hDFFF, 16'hD800));
        default: begin
          case ($urandom_range(5))
            0: cp = 16'h0000;
            1: cp = 16'h007F;
            2: cp = 16'h0080;
            3: cp = 16'h07FF;
            4: cp = 16'h0800;
            default: cp = 16'hFFFF;
          endcase
        end
      endcase
      send_uescape(cp, pick >= 84);
    end else if (pick < 95) begin
      send_item(CH_QUOTE);
    end else begin
      c = 8'($urandom_range(255));
      send_item(c);
    end
  endtask

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    decoded_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      n_results++;
      if (out_ch.string_done) n_strings++;
      if (decoded_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result byte=%02h bv=%0b done=%0b last=%0b",
                                  out_ch.out_byte, out_ch.byte_valid,
                                  out_ch.string_done, out_ch.last));
      end else begin
        want = decoded_q.pop_front();
        if (out_ch.out_byte !== want.ob)
          report_mismatch($sformatf("out_byte got %02h want %02h", out_ch.out_byte, want.ob));
        if (out_ch.byte_valid !== want.bv)
          report_mismatch($sformatf("byte_valid got %0b want %0b",
                                    out_ch.byte_valid, want.bv));
        if (out_ch.string_done !== want.done)
          report_mismatch($sformatf("string_done got %0b want %0b",
                                    out_ch.string_done, want.done));
        if (out_ch.last !== want.last)
          report_mismatch($sformatf("last got %0b want %0b", out_ch.last, want.last));
      end
    end
  end

  initial begin
    int target;
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.in_byte <= 8'h00;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (int p = 0; p < 4; p++) begin
      idle_pct  = IDLE_PCT[p];
      stall_pct = STALL_PCT[p];
      if (p == 0)
        for (int r = 0; r < DIR_ROWS; r++)
          send_item(DIR_TAB[r].b, DIR_TAB[r].kind, DIR_TAB[r].ob);
      target = n_items + ITEMS_PER_PHASE;
      while (n_items < target) send_token();
    end

    in_ch.valid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("sent %0d raw bytes over four handshake pressure phases", n_items);
    $display("checked %0d decoded results, %0d of them string ends", n_results, n_strings);
    if (n_errors == 0) begin
      $display("json_string_unescape verification clean");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("json_string_unescape verification failed");
    end
    $finish;
  end

endmodule
